### rtl/skt_pkg.sv
// Package with the shared constants, result codes and control types of the sorted key table.
`default_nettype none
package skt_pkg;

   localparam int CAPACITY    = 16;
   localparam int KEY_BITS    = 16;
   localparam int ID_BITS     = 16;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 32;
   localparam int CODE_BITS   = 2;
   localparam int ENTRY_BITS  = 5;
   localparam int OCC_BITS    = $clog2(CAPACITY + 1);

   typedef logic [KEY_BITS-1:0]    key_type;
   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [OCC_BITS-1:0]    occ_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [CODE_BITS-1:0] {
      RC_DONE      = 2'd0,
      RC_DUPLICATE = 2'd1,
      RC_NOT_FOUND = 2'd2,
      RC_FULL      = 2'd3
   } code_type;

   typedef struct packed {
      logic     load;
      logic     commit;
      logic     write;
      code_type code;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     found;
      logic     full;
   } stat_type;

endpackage
`default_nettype wire

### rtl/skt_req_if.sv
// Request channel of the sorted key table: valid, ready and one request item.
`default_nettype none
interface skt_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] process_id;
   logic [1:0]  proc_state;
   logic [31:0] cmd_count;

   modport source (output valid, output mode, output process_id, output proc_state,
                   output cmd_count, input ready);
   modport sink   (input valid, input mode, input process_id, input proc_state,
                   input cmd_count, output ready);
endinterface
`default_nettype wire

### rtl/skt_rsp_if.sv
// Response channel of the sorted key table: valid, ready and one result item.
`default_nettype none
interface skt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_code;
   logic [4:0] entry_count;

   modport source (output valid, output result_code, output entry_count, input ready);
   modport sink   (input valid, input result_code, input entry_count, output ready);
endinterface
`default_nettype wire

### rtl/skt_ctrl.sv
// Controller state machine that sequences capture, update and response of each request.
`default_nettype none
module skt_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  skt_pkg::stat_type  stat,
   output skt_pkg::cmd_type   cmd
);
   import skt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.code   = RC_DONE;
      cmd.load   = req_valid && req_ready_ff;
      cmd.commit = (state_ff == ST_EXEC);
      if (stat.mode == MODE_INSERT) begin
         if (stat.found) begin
            cmd.code = RC_DUPLICATE;
         end else if (stat.full) begin
            cmd.code = RC_FULL;
         end else begin
            cmd.write = cmd.commit;
         end
      end else begin
         if (stat.found) begin
            cmd.write = cmd.commit;
         end else begin
            cmd.code = RC_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### rtl/skt_datapath.sv
// Datapath with the sorted cell row, parallel key compare, shift update and result register.
`default_nettype none
module skt_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_mode,
   input  wire logic [15:0]       req_process_id,
   input  wire logic [1:0]        req_proc_state,
   input  wire logic [31:0]       req_cmd_count,
   input  skt_pkg::cmd_type       cmd,
   output skt_pkg::stat_type      stat,
   output logic [1:0]             rsp_result_code,
   output logic [4:0]             rsp_entry_count
);
   import skt_pkg::*;

   mode_type   mode_ff;
   key_type    key_ff;
   status_type status_ff;
   count_type  count_ff;

   key_type    cell_key_ff    [CAPACITY];
   status_type cell_status_ff [CAPACITY];
   count_type  cell_count_ff  [CAPACITY];
   occ_type    occ_ff;

   code_type   code_ff;
   occ_type    entries_ff;

   logic [CAPACITY-1:0] below;
   logic [CAPACITY-1:0] equal;
   occ_type             occ_in;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         below[i] = (OCC_BITS'(i) < occ_ff) && (cell_key_ff[i] < key_ff);
         equal[i] = (OCC_BITS'(i) < occ_ff) && (cell_key_ff[i] == key_ff);
      end
   end

   assign stat.mode  = mode_ff;
   assign stat.found = |equal;
   assign stat.full  = (occ_ff == OCC_BITS'(CAPACITY));

   always_comb begin
      occ_in = occ_ff;
      if (cmd.write) begin
         if (mode_ff == MODE_INSERT) begin
            occ_in = occ_ff + OCC_BITS'(1);
         end else begin
            occ_in = occ_ff - OCC_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= mode_type'(req_mode);
         key_ff    <= req_process_id[KEY_BITS-1:0];
         status_ff <= req_proc_state;
         count_ff  <= req_cmd_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (!below[i]) begin
               if (mode_ff == MODE_INSERT) begin
                  if (i == 0 || below[(i == 0) ? 0 : i - 1]) begin
                     cell_key_ff[i]    <= key_ff;
                     cell_status_ff[i] <= status_ff;
                     cell_count_ff[i]  <= count_ff;
                  end else begin
                     cell_key_ff[i]    <= cell_key_ff[(i == 0) ? 0 : i - 1];
                     cell_status_ff[i] <= cell_status_ff[(i == 0) ? 0 : i - 1];
                     cell_count_ff[i]  <= cell_count_ff[(i == 0) ? 0 : i - 1];
                  end
               end else if (i < CAPACITY - 1) begin
                  cell_key_ff[i]    <= cell_key_ff[(i < CAPACITY - 1) ? i + 1 : i];
                  cell_status_ff[i] <= cell_status_ff[(i < CAPACITY - 1) ? i + 1 : i];
                  cell_count_ff[i]  <= cell_count_ff[(i < CAPACITY - 1) ? i + 1 : i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         code_ff    <= cmd.code;
         entries_ff <= occ_in;
      end
   end

   assign rsp_result_code = code_ff;
   assign rsp_entry_count = ENTRY_BITS'(entries_ff);

endmodule
`default_nettype wire

### rtl/sorted_key_table.sv
// Top level of the sorted key table: controller and datapath joined to the item channels.
// The table holds up to CAPACITY records in a row of cells kept in ascending order of
// process id, with no id held twice. A request item is captured at its acceptance. In the
// next cycle every cell compares its key with the request at once and the row shifts open
// or closed. The registered result item is presented from the cycle after that and is held
// until it is accepted. The next request item is accepted only after the result item has
// been accepted, so a new request is not taken while the last one is still in flight.
// Inserting a held id answers duplicate even when the table is full, a new id into a full
// table answers full, and removing an absent id answers not found; entry_count is the
// number of records held after the request. No clearing pass is needed after reset.
`default_nettype none
module sorted_key_table (
   input wire logic  clock,
   input wire logic  reset,
   skt_req_if.sink   req_ch,
   skt_rsp_if.source rsp_ch
);
   import skt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   skt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_ch.mode),
      .req_process_id  (req_ch.process_id),
      .req_proc_state  (req_ch.proc_state),
      .req_cmd_count   (req_ch.cmd_count),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_result_code (rsp_ch.result_code),
      .rsp_entry_count (rsp_ch.entry_count)
   );

endmodule
`default_nettype wire

### bench/tb_sorted_key_table.sv
// Self-checking testbench for the sorted key table: directed and random request traffic against a predictor.
`timescale 1ns / 1ps

module tb_sorted_key_table;
   import skt_pkg::*;

   localparam int POOL_SIZE = 24;

   typedef struct packed {
      code_type                code;
      logic [ENTRY_BITS-1:0]   entries;
   } table_reply_type;

   class table_scoreboard;
      key_type         keys[CAPACITY];
      status_type      states[CAPACITY];
      count_type       counts[CAPACITY];
      int              held;
      int              errors;
      table_reply_type expected_replies[$];

      function new();
         held = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      task report(input string what);
         if (errors < 40) $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      function void note_request(input mode_type m, input key_type id, input status_type st,
                                 input count_type cnt);
         int pos;
         int j;
         table_reply_type r;
         pos = 0;
         while (pos < held && keys[pos] < id) pos++;
         if (m == MODE_INSERT) begin
            if (pos < held && keys[pos] == id) begin
               r.code = RC_DUPLICATE;
            end else if (held >= CAPACITY) begin
               r.code = RC_FULL;
            end else begin
               for (j = held; j > pos; j--) begin
                  keys[j] = keys[j-1];
                  states[j] = states[j-1];
                  counts[j] = counts[j-1];
               end
               keys[pos] = id;
               states[pos] = st;
               counts[pos] = cnt;
               held++;
               r.code = RC_DONE;
            end
         end else begin
            if (pos >= held || keys[pos] != id) begin
               r.code = RC_NOT_FOUND;
            end else begin
               for (j = pos; j + 1 < held; j++) begin
                  keys[j] = keys[j+1];
                  states[j] = states[j+1];
                  counts[j] = counts[j+1];
               end
               held--;
               r.code = RC_DONE;
            end
         end
         r.entries = ENTRY_BITS'(held);
         expected_replies.push_back(r);
      endfunction

      task check_response(input logic [CODE_BITS-1:0] code, input logic [ENTRY_BITS-1:0] entries);
         table_reply_type want;
         if (expected_replies.size() == 0) begin
            report($sformatf("result item with none expected: code %0d entries %0d",
                             code, entries));
            return;
         end
         want = expected_replies.pop_front();
         if (code !== want.code)
            report($sformatf("result_code %0d, expected %0d (%s)", code, want.code,
                             want.code.name()));
         if (entries !== want.entries)
            report($sformatf("entry_count %0d, expected %0d", entries, want.entries));
      endtask
   endclass

   logic clock;
   logic reset;
   int   burst_left = 0;
   int unsigned rx_tick = 0;
   int   rx_phase = 0;

   table_scoreboard table_sb = new();

   skt_req_if req_if();
   skt_rsp_if rsp_if();

   sorted_key_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 40 == 0) rx_phase <= $urandom_range(0, 3);
      case (rx_phase)
         0: begin
            rsp_if.ready <= 1'b1;
         end
         1: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_if.ready <= (rx_tick[1:0] == 2'd0);
         end
         default: begin
            rsp_if.ready <= (rx_tick % 13 >= 9);
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         table_sb.check_response(rsp_if.result_code, rsp_if.entry_count);
   end

   task automatic issue(input mode_type m, input key_type id, input status_type st,
                        input count_type cnt);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid      <= 1'b1;
      req_if.mode       <= m;
      req_if.process_id <= id;
      req_if.proc_state <= st;
      req_if.cmd_count  <= cnt;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      table_sb.note_request(m, id, st, cnt);
   endtask

   initial begin : stimulus
      key_type  key_pool[POOL_SIZE];
      int       lean;
      int       threshold;
      mode_type m;
      key_type  id;

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.mode       <= MODE_INSERT;
      req_if.process_id <= '0;
      req_if.proc_state <= '0;
      req_if.cmd_count  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      issue(MODE_REMOVE, 16'h0064, 2'd0, 32'h0);
      issue(MODE_INSERT, 16'h8000, 2'd0, 32'h0000_0000);
      issue(MODE_INSERT, 16'h0000, 2'd1, 32'hFFFF_FFFF);
      issue(MODE_INSERT, 16'hFFFF, 2'd2, 32'h5A5A_5A5A);
      issue(MODE_INSERT, 16'h8000, 2'd1, 32'h1);
      issue(MODE_INSERT, 16'h4000, 2'd3, 32'hA5A5_A5A5);
      issue(MODE_REMOVE, 16'h1234, 2'd3, 32'hFFFF_FFFF);
      issue(MODE_REMOVE, 16'hFFFF, 2'd0, 32'h0);
      issue(MODE_REMOVE, 16'h0000, 2'd0, 32'h0);
      for (int i = 0; i < CAPACITY - 2; i++)
         issue(MODE_INSERT, key_type'(16'hFFFF - i * 16'h1111), status_type'(i % 4), $urandom);
      issue(MODE_INSERT, 16'h0001, 2'd2, 32'h7);
      issue(MODE_INSERT, 16'h8000, 2'd2, 32'h8);

      lean = 2;
      for (int n = 0; n < 850; n++) begin
         if (n % 150 == 0) begin
            foreach (key_pool[k]) key_pool[k] = key_type'($urandom);
            key_pool[0] = '0;
            key_pool[1] = '1;
         end
         if (n % 60 == 0) lean = $urandom_range(0, 2);
         threshold = (lean == 0) ? 80 : (lean == 1) ? 20 : 50;
         m = ($urandom_range(0, 99) < threshold) ? MODE_INSERT : MODE_REMOVE;
         if ($urandom_range(0, 99) < 85)
            id = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            id = key_type'($urandom);
         issue(m, id, status_type'($urandom_range(0, 3)), count_type'($urandom));
      end
      req_if.valid <= 1'b0;

      while (table_sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (table_sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
